// ----- rtl/core/biq_pkg.sv -----
// Shared types, constants and table functions for the biquad filter core.
// No dependencies; imported by every module of the core but biq_ram.
`timescale 1ns / 1ps

package biq_pkg;

   // Sample and coefficient formats
   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 24;
   localparam int ATAN_DEPTH_DEF = 1024;

   // Register indexes on the csr channel
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FB_SHAPE = 3'd5;

   // Reset values (Q3.20 unity for b0)
   localparam logic signed [COEF_W-1:0] COEF_B0_RST = 24'sd1048576;

   // Saturation limits of Q1.23
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_set_type;

   // ------------------------------------------------------------------
   // Arctangent table generation, evaluated at elaboration only.
   // Fixed point Q2.30 with an integer alternating series.
   // ------------------------------------------------------------------
   localparam longint ONE_Q30  = 64'sd1 << 30;
   localparam longint HALF_Q30 = 64'sd1 << 29;
   localparam int     SERIES_TERMS = 24;

   // Unsigned restoring division, floor of n / den for nonnegative values
   function automatic longint udiv(longint n, longint den);
      logic [63:0] num;
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] dv;
      int          b;
      num = 64'(n);
      dv  = 64'(den);
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= dv) begin
            rem    = rem - dv;
            quo[b] = 1'b1;
         end
      end
      return longint'(quo);
   endfunction

   // atan(t) for 0 <= t <= 0.5
   function automatic longint atan_series(longint t);
      longint t2;
      longint p;
      longint sum;
      longint term;
      int     k;
      t2  = (t * t + HALF_Q30) >>> 30;
      p   = t;
      sum = t;
      for (k = 1; k <= SERIES_TERMS; k++) begin
         p    = (p * t2 + HALF_Q30) >>> 30;
         term = udiv(p, longint'(2 * k + 1));
         if (k % 2 == 1) sum = sum - term;
         else            sum = sum + term;
      end
      return sum;
   endfunction

   // pi/4 by Machin's formula
   function automatic longint quarter_pi();
      longint a5;
      longint a239;
      a5   = atan_series(udiv(ONE_Q30 + 2, 64'sd5));
      a239 = atan_series(udiv(ONE_Q30 + 119, 64'sd239));
      return 4 * a5 - a239;
   endfunction

   // atan(u) for 0 <= u <= 1, reflected about one for the upper half
   function automatic longint atan_pos(longint u, longint qpi);
      longint den;
      longint t;
      if (u <= HALF_Q30) return atan_series(u);
      den = ONE_Q30 + u;
      t   = udiv((ONE_Q30 - u) * ONE_Q30 + (den >>> 1), den);
      return qpi - atan_series(t);
   endfunction

   // Table entry i of a d-entry table: atan of the bucket centre, Q1.23
   function automatic logic [SAMPLE_W-1:0] atan_entry(int i, int d, longint qpi);
      longint c;
      longint u;
      longint a;
      longint r;
      logic   neg;
      c   = udiv(longint'(2 * i + 1) * (ONE_Q30 * 2) + longint'(d), longint'(2 * d))
            - ONE_Q30;
      neg = (c < 0);
      u   = neg ? -c : c;
      if (u > ONE_Q30) u = ONE_Q30;
      a = atan_pos(u, qpi);
      r = (a + 64) >>> 7;
      if (neg) r = -r;
      return r[SAMPLE_W-1:0];
   endfunction

endpackage

// ----- rtl/core/biq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module biq_ram #(
   parameter int Width = 24,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/biq_atan_rom.sv -----
// Arctangent lookup: table RAM loaded by a sweep after reset, indexed by sample.
// Depends on biq_pkg (table functions) and biq_ram.
`timescale 1ns / 1ps

module biq_atan_rom #(
   parameter int Depth = biq_pkg::ATAN_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 lookup_en,
   input  logic signed [biq_pkg::SAMPLE_W-1:0]  sample,
   output logic [biq_pkg::SAMPLE_W-1:0]         atan_q,
   output logic                                 table_ready
);
   import biq_pkg::*;

   localparam int AW = $clog2(Depth);
   localparam int PW = SAMPLE_W + AW;

   typedef logic [SAMPLE_W-1:0] tbl_type [Depth];

   function automatic tbl_type build_tbl();
      tbl_type tbl;
      longint  qpi;
      int      i;
      qpi = quarter_pi();
      for (i = 0; i < Depth; i++) tbl[i] = atan_entry(i, Depth, qpi);
      return tbl;
   endfunction

   localparam tbl_type ATAN_TBL = build_tbl();

   logic          filling_ff, filling_in;
   logic [AW-1:0] fill_cnt_ff, fill_cnt_in;
   logic          fill_last;

   logic [SAMPLE_W-1:0] biased;
   logic [PW-1:0]       scaled;
   logic [AW-1:0]       rd_addr;

   // load sweep, one entry per cycle after reset
   assign fill_last = (fill_cnt_ff == AW'(Depth - 1));

   always_comb begin
      filling_in  = filling_ff;
      fill_cnt_in = fill_cnt_ff;
      if (filling_ff) begin
         fill_cnt_in = fill_cnt_ff + AW'(1);
         if (fill_last) filling_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filling_ff  <= 1'b1;
         fill_cnt_ff <= '0;
      end else begin
         filling_ff  <= filling_in;
         fill_cnt_ff <= fill_cnt_in;
      end
   end

   // bucket index = floor((y + 2^23) * Depth / 2^24)
   assign biased  = {~sample[SAMPLE_W-1], sample[SAMPLE_W-2:0]};
   assign scaled  = PW'(biased) * PW'(Depth);
   assign rd_addr = scaled[SAMPLE_W +: AW];

   biq_ram #(
      .Width (SAMPLE_W),
      .Depth (Depth)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (filling_ff),
      .wr_addr (fill_cnt_ff),
      .wr_data (ATAN_TBL[fill_cnt_ff]),
      .rd_en   (lookup_en),
      .rd_addr (rd_addr),
      .rd_data (atan_q)
   );

   assign table_ready = ~filling_ff;

endmodule

// ----- rtl/core/biq_mac.sv -----
// Biquad multiply-accumulate with round-half-up and Q1.23 saturation.
// Depends on biq_pkg (coefficient struct, sample limits).
`timescale 1ns / 1ps

module biq_mac (
   input  biq_pkg::coef_set_type                coef,
   input  logic signed [biq_pkg::SAMPLE_W-1:0]  x0,
   input  logic signed [biq_pkg::SAMPLE_W-1:0]  x1,
   input  logic signed [biq_pkg::SAMPLE_W-1:0]  x2,
   input  logic signed [biq_pkg::SAMPLE_W-1:0]  y1,
   input  logic signed [biq_pkg::SAMPLE_W-1:0]  y2,
   output logic signed [biq_pkg::SAMPLE_W-1:0]  y
);
   import biq_pkg::*;

   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W  = PROD_W + 3;
   localparam int RND_W  = ACC_W + 1;
   localparam int FRAC_SHIFT = 20;
   localparam int YF_W   = RND_W - FRAC_SHIFT;

   logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
   logic signed [ACC_W-1:0]  acc;
   logic signed [RND_W-1:0]  acc_rnd;
   logic signed [YF_W-1:0]   y_full;
   logic                     in_range;

   // five independent products
   assign p_b0 = PROD_W'(coef.b0) * PROD_W'(x0);
   assign p_b1 = PROD_W'(coef.b1) * PROD_W'(x1);
   assign p_b2 = PROD_W'(coef.b2) * PROD_W'(x2);
   assign p_a1 = PROD_W'(coef.a1) * PROD_W'(y1);
   assign p_a2 = PROD_W'(coef.a2) * PROD_W'(y2);

   // exact Q4.43 sum
   assign acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
              - ACC_W'(p_a1) - ACC_W'(p_a2);

   // add half an output LSB, then floor to Q1.23
   assign acc_rnd = RND_W'(acc) + RND_W'(64'sd1 << (FRAC_SHIFT - 1));
   assign y_full  = $signed(acc_rnd[RND_W-1:FRAC_SHIFT]);

   // saturate when the bits above the sample width are not a sign extension
   assign in_range = (y_full[YF_W-1:SAMPLE_W-1] == '0)
                  || (y_full[YF_W-1:SAMPLE_W-1] == '1);

   always_comb begin
      if (in_range)               y = y_full[SAMPLE_W-1:0];
      else if (y_full[YF_W-1])    y = SAMPLE_MIN;
      else                        y = SAMPLE_MAX;
   end

endmodule

// ----- rtl/core/biquad_filter_with_feedback_clip_core.sv -----
// Top level of the biquad filter core: channels, registers, delay lines.
// Depends on biq_pkg, biq_mac, biq_atan_rom (and biq_ram below it).
//
// Usage:
//   req_* carries one signed Q1.23 sample per transfer; rsp_* returns the
//   filtered, saturated Q1.23 sample, one per input, in order.
//   csr_* writes a register: index 0..4 = b0, b1, b2, a1, a2 (Q3.20),
//   index 5 = feedback shaping (0 plain, 1 arctangent). Other indexes are
//   ignored. Write only while no sample is in flight.
// Timing:
//   A sample accepted at an edge has its result registered and valid after
//   that edge. Throughput is one sample per cycle unless rsp_tready stalls;
//   the filter equation and the arctangent table address are combinational,
//   and the table read register doubles as the first feedback tap.
// Reset:
//   Synchronous, active high. Coefficients return to b0 = 1.0, the rest to
//   zero, delay lines clear. The arctangent table is then loaded, all
//   ATAN_TABLE_DEPTH entries (1024 by default), with req_tready low; csr
//   writes are taken during that time.
// Backpressure:
//   The result register holds while rsp_tready is low; a new sample is
//   taken in the same cycle the held result leaves.
`timescale 1ns / 1ps

module biquad_filter_with_feedback_clip_core #(
   parameter int ATAN_TABLE_DEPTH = biq_pkg::ATAN_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // input samples
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [biq_pkg::SAMPLE_W-1:0]       req_tdata,   // [23:0] sample_in
   // filtered samples
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [biq_pkg::SAMPLE_W-1:0]       rsp_tdata,   // [23:0] sample_out
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [biq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [biq_pkg::COEF_W-1:0]         csr_wdata
);
   import biq_pkg::*;

   coef_set_type coef_ff;
   logic         shape_ff;

   logic signed [SAMPLE_W-1:0] x1_ff, x2_ff;
   logic signed [SAMPLE_W-1:0] y1_ff, y2_ff;
   logic                       y1_sel_ff;   // y1 tap comes from the atan table
   logic signed [SAMPLE_W-1:0] y1_tap;

   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        rsp_data_ff;

   logic                       req_xfer;
   logic                       csr_xfer;
   logic                       table_ready;
   logic signed [SAMPLE_W-1:0] x0;
   logic signed [SAMPLE_W-1:0] y_new;
   logic [SAMPLE_W-1:0]        atan_q;

   // handshakes
   assign req_tready = table_ready && (!rsp_valid_ff || rsp_tready);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid && csr_ready;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= COEF_B0_RST;
         coef_ff.b1 <= '0;
         coef_ff.b2 <= '0;
         coef_ff.a1 <= '0;
         coef_ff.a2 <= '0;
         shape_ff   <= 1'b0;
      end else if (csr_xfer) begin
         case (csr_index)
            CSR_COEF_B0:  coef_ff.b0 <= $signed(csr_wdata);
            CSR_COEF_B1:  coef_ff.b1 <= $signed(csr_wdata);
            CSR_COEF_B2:  coef_ff.b2 <= $signed(csr_wdata);
            CSR_COEF_A1:  coef_ff.a1 <= $signed(csr_wdata);
            CSR_COEF_A2:  coef_ff.a2 <= $signed(csr_wdata);
            CSR_FB_SHAPE: shape_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // first feedback tap: raw output or table word read at the last transfer
   assign y1_tap = y1_sel_ff ? $signed(atan_q) : y1_ff;
   assign x0     = $signed(req_tdata);

   biq_mac u_mac (
      .coef (coef_ff),
      .x0   (x0),
      .x1   (x1_ff),
      .x2   (x2_ff),
      .y1   (y1_tap),
      .y2   (y2_ff),
      .y    (y_new)
   );

   biq_atan_rom #(
      .Depth (ATAN_TABLE_DEPTH)
   ) u_atan (
      .clock       (clock),
      .reset       (reset),
      .lookup_en   (req_xfer),
      .sample      (y_new),
      .atan_q      (atan_q),
      .table_ready (table_ready)
   );

   // delay lines shift on every input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff     <= '0;
         x2_ff     <= '0;
         y1_ff     <= '0;
         y2_ff     <= '0;
         y1_sel_ff <= 1'b0;
      end else if (req_xfer) begin
         x1_ff     <= x0;
         x2_ff     <= x1_ff;
         y1_ff     <= y_new;
         y1_sel_ff <= shape_ff;
         y2_ff     <= y1_tap;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)                      rsp_valid_ff <= 1'b0;
      else if (req_xfer)              rsp_valid_ff <= 1'b1;
      else if (rsp_tready)            rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_xfer) rsp_data_ff <= y_new;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // no sample may enter while the table is still loading
   a_no_xfer_loading : assert property (@(posedge clock) disable iff (reset)
      !table_ready |-> !req_tready)
      else $error("input taken during table load");

   // every transfer leaves a result behind
   a_rsp_after_xfer : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_tvalid)
      else $error("no result after input transfer");

   // unshaped feedback stores exactly the delivered output
   a_plain_feedback : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !shape_ff) |=> (!y1_sel_ff && y1_ff == $signed(rsp_tdata)))
      else $error("plain feedback tap differs from output");

   // input delay takes the accepted sample
   a_input_delay : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (x1_ff == $signed($past(req_tdata))))
      else $error("input delay not loaded with accepted sample");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for biquad_filter_with_feedback_clip_core: drives samples and
// register writes, predicts each filtered sample and compares it on the result stream.
// Depends on biq_pkg (types, register indexes) and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
   import biq_pkg::*;

   localparam int      ATAN_ENTRIES  = 1024;
   localparam longint  Q30_UNIT      = 64'sd1 << 30;
   localparam longint  Q30_HALF      = 64'sd1 << 29;
   localparam int      ARCTAN_TERMS  = 24;
   localparam longint  Q123_MAX      = 64'sd8388607;
   localparam longint  Q123_MIN      = -64'sd8388608;
   localparam int      IDLE_PCT      = 12;
   localparam int      WATCHDOG_LIM  = 20000;
   localparam int      RANDOM_PHASES = 10;
   localparam int      QUIET_PHASE   = 4;

   // indexes past the register list, must be ignored by the core
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [SAMPLE_W-1:0] S_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] S_MIN = 24'h800000;
   localparam logic [COEF_W-1:0]   C_MAX = 24'h7FFFFF;
   localparam logic [COEF_W-1:0]   C_MIN = 24'h800000;

   // ------------------------------------------------------------------
   // Filter predictor and store of expected output samples
   // ------------------------------------------------------------------
   class filter_scoreboard;
      logic signed [COEF_W-1:0]   b0, b1, b2, a1, a2;
      bit                         shape_on;
      logic signed [SAMPLE_W-1:0] x_hist[2];
      logic signed [SAMPLE_W-1:0] fb_hist[2];
      logic signed [SAMPLE_W-1:0] arctan_lut[ATAN_ENTRIES];
      logic [SAMPLE_W-1:0]        expected_out[$];
      int                         errors;

      function new();
         build_arctan_lut();
         b0 = COEF_B0_RST;
         b1 = '0;
         b2 = '0;
         a1 = '0;
         a2 = '0;
         shape_on = 1'b0;
         x_hist[0] = '0;
         x_hist[1] = '0;
         fb_hist[0] = '0;
         fb_hist[1] = '0;
         errors = 0;
      endfunction

      // alternating series, Q2.30, valid for 0 <= t <= 0.5
      function longint arctan_q30(longint t);
         longint t2;
         longint p;
         longint sum;
         int     k;
         t2  = (t * t + Q30_HALF) / Q30_UNIT;
         p   = t;
         sum = t;
         for (k = 1; k <= ARCTAN_TERMS; k++) begin
            p = (p * t2 + Q30_HALF) / Q30_UNIT;
            if (k % 2 == 1) sum = sum - p / (2 * k + 1);
            else            sum = sum + p / (2 * k + 1);
         end
         return sum;
      endfunction

      // bucket centers over [-1, 1), arctangent rounded to Q1.23
      function void build_arctan_lut();
         longint qpi;
         longint ctr;
         longint u;
         longint den;
         longint a;
         longint r;
         longint i;
         bit     neg;
         qpi = 4 * arctan_q30((Q30_UNIT + 2) / 5) - arctan_q30((Q30_UNIT + 119) / 239);
         for (i = 0; i < ATAN_ENTRIES; i++) begin
            ctr = ((2 * i + 1) * (Q30_UNIT * 2) + ATAN_ENTRIES) / (2 * ATAN_ENTRIES)
                  - Q30_UNIT;
            neg = (ctr < 0);
            u   = neg ? -ctr : ctr;
            if (u > Q30_UNIT) u = Q30_UNIT;
            if (u <= Q30_HALF) begin
               a = arctan_q30(u);
            end else begin
               // reflect: atan(u) = pi/4 - atan((1-u)/(1+u))
               den = Q30_UNIT + u;
               a   = qpi - arctan_q30(((Q30_UNIT - u) * Q30_UNIT + den / 2) / den);
            end
            r = (a + 64) / 128;
            if (neg) r = -r;
            arctan_lut[i] = r[SAMPLE_W-1:0];
         end
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
         case (idx)
            CSR_COEF_B0:  b0 = data;
            CSR_COEF_B1:  b1 = data;
            CSR_COEF_B2:  b2 = data;
            CSR_COEF_A1:  a1 = data;
            CSR_COEF_A2:  a2 = data;
            CSR_FB_SHAPE: shape_on = data[0];
            default: ;
         endcase
      endfunction

      // accepted input sample: run the difference equation, queue the output
      function void note_sample(logic [SAMPLE_W-1:0] x_bits);
         logic signed [SAMPLE_W-1:0] x;
         logic signed [SAMPLE_W-1:0] fb;
         longint                     acc;
         longint                     y;
         longint                     idx;
         x   = x_bits;
         acc = longint'(b0) * longint'(x)
             + longint'(b1) * longint'(x_hist[0])
             + longint'(b2) * longint'(x_hist[1])
             - longint'(a1) * longint'(fb_hist[0])
             - longint'(a2) * longint'(fb_hist[1]);
         // round half up from Q4.43 to Q1.23, then clip
         y = (acc + (64'sd1 << 19)) >>> 20;
         if (y > Q123_MAX) y = Q123_MAX;
         if (y < Q123_MIN) y = Q123_MIN;
         if (shape_on) begin
            idx = ((y + (64'sd1 << 23)) * ATAN_ENTRIES) >> 24;
            if (idx >= ATAN_ENTRIES) idx = ATAN_ENTRIES - 1;
            fb = arctan_lut[idx];
         end else begin
            fb = y[SAMPLE_W-1:0];
         end
         x_hist[1]  = x_hist[0];
         x_hist[0]  = x;
         fb_hist[1] = fb_hist[0];
         fb_hist[0] = fb;
         expected_out.push_back(y[SAMPLE_W-1:0]);
      endfunction

      function void check_output(logic [SAMPLE_W-1:0] actual);
         logic [SAMPLE_W-1:0] want;
         if (expected_out.size() == 0) begin
            errors++;
            $display("%0t: unexpected output sample, expected none, actual %0d",
                     $time, $signed(actual));
         end else begin
            want = expected_out.pop_front();
            if (actual !== want) begin
               errors++;
               $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                        $time, $signed(want), $signed(actual));
            end
         end
      endfunction

      function int pending();
         return expected_out.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, DUT
   // ------------------------------------------------------------------
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [SAMPLE_W-1:0]  req_tdata  = '0;   // [23:0] sample_in
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_tdata;         // [23:0] sample_out
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [COEF_W-1:0]    csr_wdata  = '0;

   bit                   idle_ok    = 1'b1;
   int                   quiet_cycles = 0;
   filter_scoreboard     sb;

   always #5 clock = ~clock;

   biquad_filter_with_feedback_clip_core #(
      .ATAN_TABLE_DEPTH(ATAN_ENTRIES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // result side backpressure
   always @(posedge clock) begin
      rsp_tready <= !reset && (!idle_ok || $urandom_range(99) >= IDLE_PCT);
   end

   // transfer monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_wdata);
         if (req_tvalid && req_tready) sb.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_output(rsp_tdata);
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready)
             || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIM) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // valid stays high between back-to-back samples; drops only for a gap
   task automatic send_sample(logic [SAMPLE_W-1:0] x);
      if (idle_ok) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(logic [COEF_W-1:0] c_b0, logic [COEF_W-1:0] c_b1,
                                logic [COEF_W-1:0] c_b2, logic [COEF_W-1:0] c_a1,
                                logic [COEF_W-1:0] c_a2, logic [COEF_W-1:0] shape_word,
                                bit with_spare);
      if (with_spare) write_reg(CSR_SPARE_LO, COEF_W'($urandom()));
      write_reg(CSR_COEF_B0, c_b0);
      write_reg(CSR_COEF_B1, c_b1);
      write_reg(CSR_COEF_B2, c_b2);
      write_reg(CSR_COEF_A1, c_a1);
      write_reg(CSR_COEF_A2, c_a2);
      write_reg(CSR_FB_SHAPE, shape_word);
      if (with_spare) write_reg(CSR_SPARE_HI, COEF_W'($urandom()));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // hold off the sender until every output sample is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      int v;
      case ($urandom_range(9))
         0:          return S_MIN;
         1:          return S_MAX;
         2, 3, 4, 5: return SAMPLE_W'($urandom());
         default: begin
            v = int'($urandom_range(0, 131072)) - 65536;
            return v[SAMPLE_W-1:0];
         end
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] rand_bounded(int lim);
      int v;
      v = int'($urandom_range(0, 2 * lim)) - lim;
      return v[COEF_W-1:0];
   endfunction

   function automatic logic [COEF_W-1:0] rand_wild();
      case ($urandom_range(4))
         0:       return C_MIN;
         1:       return C_MAX;
         default: return COEF_W'($urandom());
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      logic [COEF_W-1:0] shape_word;
      int                n_items;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: output equals input; spare indexes must not disturb
      apply_setting(COEF_B0_RST, '0, '0, '0, '0, '0, 1'b1);
      send_sample('0);
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(24'h000001);
      send_sample(24'hFFFFFF);
      send_sample(24'h555555);
      send_sample(24'hAAAAAA);
      drain();

      // extreme coefficients, arctangent feedback, upper shaping bits masked
      apply_setting(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, 24'hFFFFFF, 1'b0);
      send_sample(S_MAX);
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(S_MIN);
      send_sample(S_MAX);
      send_sample('0);
      send_sample(24'h000001);
      drain();

      // opposite extremes, plain feedback with upper bits set
      apply_setting(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 24'hFFFFFE, 1'b1);
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(S_MAX);
      send_sample('0);
      send_sample(24'hFFFFFF);
      send_sample(S_MIN);
      send_sample(24'h123456);
      drain();

      // random phases: mostly tame filters, some wild coefficient sets
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         shape_word    = COEF_W'($urandom());
         shape_word[0] = ph[0];
         if ($urandom_range(3) == 0)
            apply_setting(rand_wild(), rand_wild(), rand_wild(), rand_wild(), rand_wild(),
                          shape_word, 1'($urandom_range(1)));
         else
            apply_setting(rand_bounded(1048576), rand_bounded(1048576),
                          rand_bounded(1048576), rand_bounded(1992294),
                          rand_bounded(943718), shape_word, 1'($urandom_range(1)));
         idle_ok <= (ph != QUIET_PHASE);
         @(posedge clock);
         n_items = $urandom_range(150, 240);
         repeat (n_items) send_sample(rand_sample());
         drain();
      end

      if (sb.errors == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/biq_pkg.sv
rtl/core/biq_ram.sv
rtl/core/biq_atan_rom.sv
rtl/core/biq_mac.sv
rtl/core/biquad_filter_with_feedback_clip_core.sv
test/tb_top.sv
